// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define WTS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// expression holds at every edge out of reset
`define WTS_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);
`else
`define WTS_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define WTS_ASSERT_ALWAYS(label, clk, rst, expr, msg)
`endif

`endif

// ===== rtl/wts_pkg.sv =====
package wts_pkg;

   localparam int DEPTH      = 32;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   localparam int CODE_W     = 10;
   localparam int TEMP_W     = 16;
   localparam int THR_W      = 14;
   localparam int ZONE_W     = 2;
   localparam int STORED_W   = 6;

   localparam int FULL_SCALE = 50000;
   localparam int CODE_MAX   = 1023;

   localparam int PROD_W     = CODE_W + TEMP_W;
   localparam int SUM_W      = TEMP_W + CNT_W;
   localparam int DIV_W      = (SUM_W > PROD_W) ? SUM_W : PROD_W;
   localparam int DVS_W      = (CNT_W > CODE_W) ? CNT_W : CODE_W;

   localparam int MUL_STEP_W = $clog2(CODE_W + 1);
   localparam int DIV_STEP_W = $clog2(DIV_W + 1);

   localparam logic [ZONE_W-1:0] ZONE_COLD     = 2'd0;
   localparam logic [ZONE_W-1:0] ZONE_NORMAL   = 2'd1;
   localparam logic [ZONE_W-1:0] ZONE_CRITICAL = 2'd2;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_THRESHOLD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_THRESHOLD = 2'd1;

   localparam logic [THR_W-1:0] LOW_THR_RESET  = 14'd2000;
   localparam logic [THR_W-1:0] HIGH_THR_RESET = 14'd3000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CDIV,
      ST_WRITE,
      ST_SCAN,
      ST_MDIV,
      ST_OUT
   } wts_state_type;

   // status of a serial arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } wts_unit_stat_type;

endpackage

// ===== rtl/wts_ram.sv =====
module wts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/wts_mul.sv =====
`include "assert_macros.svh"

// shift-add multiply of the code by the full scale, one code bit per cycle
module wts_mul import wts_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [CODE_W-1:0] code,
   output wts_unit_stat_type stat,
   output logic [PROD_W-1:0] product
);

   logic [CODE_W-1:0]     mplier_ff;
   logic [PROD_W-1:0]     mcand_ff;
   logic [PROD_W-1:0]     acc_ff;
   logic [MUL_STEP_W-1:0] step_ff;
   logic                  busy_ff;
   logic                  done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            mplier_ff <= code;
            mcand_ff  <= PROD_W'(FULL_SCALE);
            acc_ff    <= '0;
            step_ff   <= MUL_STEP_W'(CODE_W);
            busy_ff   <= 1'b1;
         end else if (busy_ff) begin
            if (mplier_ff[0]) begin
               acc_ff <= acc_ff + mcand_ff;
            end
            mcand_ff  <= {mcand_ff[PROD_W-2:0], 1'b0};
            mplier_ff <= {1'b0, mplier_ff[CODE_W-1:1]};
            step_ff   <= step_ff - MUL_STEP_W'(1);
            if (step_ff == MUL_STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign product   = acc_ff;

   `WTS_ASSERT_IMP(a_mul_done_idle, clock, reset, done_ff, !busy_ff, "mul done while busy")

endmodule

// ===== rtl/wts_div.sv =====
`include "assert_macros.svh"

// restoring divider, one quotient bit per cycle
module wts_div import wts_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [DVS_W-1:0]  divisor,
   output wts_unit_stat_type stat,
   output logic [DIV_W-1:0]  quotient
);

   logic [DIV_W-1:0]      dq_ff;
   logic [DVS_W-1:0]      rem_ff;
   logic [DVS_W-1:0]      dvs_ff;
   logic [DIV_STEP_W-1:0] step_ff;
   logic                  busy_ff;
   logic                  done_ff;

   logic [DVS_W:0]        shifted;
   logic                  ge;
   logic [DVS_W-1:0]      rem_in;

   always_comb begin
      shifted = {rem_ff, dq_ff[DIV_W-1]};
      ge      = shifted >= {1'b0, dvs_ff};
      rem_in  = ge ? DVS_W'(shifted - {1'b0, dvs_ff}) : shifted[DVS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            dq_ff   <= dividend;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
            step_ff <= DIV_STEP_W'(DIV_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            // dividend bits leave at the top, quotient bits enter at the bottom
            dq_ff   <= {dq_ff[DIV_W-2:0], ge};
            rem_ff  <= rem_in;
            step_ff <= step_ff - DIV_STEP_W'(1);
            if (step_ff == DIV_STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = dq_ff;

   `WTS_ASSERT_IMP(a_div_rem_below, clock, reset, busy_ff, rem_ff < dvs_ff, "remainder not below divisor")

endmodule

// ===== rtl/windowed_temperature_stats.sv =====
// an accepted item passes the multiply, the temperature divide, the ring write, the window
// scan and the mean divide; the pace is set by the 10-step serial multiply,
// two 26-step serial divides and the window scan through the single ram read port
// the next item is taken while a finished result still waits in the output register
// reset is synchronous, active high: thresholds return to 2000 and 3000, window empties
module windowed_temperature_stats import wts_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CODE_W-1:0]    req_adc_code,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [TEMP_W-1:0]    rsp_temperature,
   output logic [ZONE_W-1:0]    rsp_zone,
   output logic [STORED_W-1:0]  rsp_stored_count,
   output logic [TEMP_W-1:0]    rsp_window_mean,
   output logic [TEMP_W-1:0]    rsp_window_max,
   output logic [TEMP_W-1:0]    rsp_window_min,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [THR_W-1:0]     csr_wdata
);

   `include "assert_macros.svh"

   wts_state_type state_ff, state_in;

   logic [THR_W-1:0]  low_thr_ff;
   logic [THR_W-1:0]  high_thr_ff;
   logic [ADDR_W-1:0] slot_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [TEMP_W-1:0] temp_ff;
   logic [ZONE_W-1:0] zone_ff;
   logic [TEMP_W-1:0] mean_ff;
   logic [CNT_W-1:0]  scan_addr_ff;
   logic              rd_pend_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [TEMP_W-1:0] max_ff;
   logic [TEMP_W-1:0] min_ff;

   logic                rsp_valid_ff;
   logic [TEMP_W-1:0]   rsp_temperature_ff;
   logic [ZONE_W-1:0]   rsp_zone_ff;
   logic [STORED_W-1:0] rsp_stored_count_ff;
   logic [TEMP_W-1:0]   rsp_window_mean_ff;
   logic [TEMP_W-1:0]   rsp_window_max_ff;
   logic [TEMP_W-1:0]   rsp_window_min_ff;

   logic              req_accept;
   logic              out_free;
   logic              out_load;
   logic              scan_issue;
   logic              mul_start;
   logic              div_start;
   logic [DIV_W-1:0]  div_dividend;
   logic [DVS_W-1:0]  div_divisor;
   logic [ZONE_W-1:0] zone_in;

   wts_unit_stat_type mul_stat;
   wts_unit_stat_type div_stat;
   logic [PROD_W-1:0] mul_product;
   logic [DIV_W-1:0]  div_quotient;
   logic [TEMP_W-1:0] ram_rd_data;

   wts_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .code    (req_adc_code),
      .stat    (mul_stat),
      .product (mul_product)
   );

   wts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quotient)
   );

   wts_ram #(
      .WIDTH (TEMP_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (state_ff == ST_WRITE),
      .wr_addr (slot_ff),
      .wr_data (temp_ff),
      .rd_en   (scan_issue),
      .rd_addr (scan_addr_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_stall    = 1'b1;
      mul_start    = 1'b0;
      div_start    = 1'b0;
      out_load     = 1'b0;
      out_free     = !rsp_valid_ff || !rsp_stall;
      req_accept   = 1'b0;
      scan_issue   = 1'b0;
      div_dividend = DIV_W'(sum_ff);
      div_divisor  = DVS_W'(cnt_ff);
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            req_accept = req_valid;
            mul_start  = req_valid;
            if (req_valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            div_dividend = DIV_W'(mul_product);
            div_divisor  = DVS_W'(CODE_MAX);
            if (mul_stat.done) begin
               div_start = 1'b1;
               state_in  = ST_CDIV;
            end
         end
         ST_CDIV: begin
            if (div_stat.done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            scan_issue = scan_addr_ff < cnt_ff;
            if (!scan_issue && !rd_pend_ff) begin
               div_start = 1'b1;
               state_in  = ST_MDIV;
            end
         end
         ST_MDIV: begin
            if (div_stat.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // cold test first, so crossed thresholds still give cold
   always_comb begin
      priority if (temp_ff < TEMP_W'(low_thr_ff)) begin
         zone_in = ZONE_COLD;
      end else if (temp_ff >= TEMP_W'(high_thr_ff)) begin
         zone_in = ZONE_CRITICAL;
      end else begin
         zone_in = ZONE_NORMAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_thr_ff   <= LOW_THR_RESET;
         high_thr_ff  <= HIGH_THR_RESET;
         slot_ff      <= '0;
         cnt_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         scan_addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_LOW_THRESHOLD) begin
               low_thr_ff <= csr_wdata;
            end else if (csr_index == CSR_HIGH_THRESHOLD) begin
               high_thr_ff <= csr_wdata;
            end
         end

         if (state_ff == ST_CDIV && div_stat.done) begin
            temp_ff <= div_quotient[TEMP_W-1:0];
         end

         if (state_ff == ST_WRITE) begin
            zone_ff      <= zone_in;
            slot_ff      <= (slot_ff == ADDR_W'(DEPTH - 1)) ? '0 : slot_ff + ADDR_W'(1);
            if (cnt_ff != CNT_W'(DEPTH)) begin
               cnt_ff <= cnt_ff + CNT_W'(1);
            end
            scan_addr_ff <= '0;
            sum_ff       <= '0;
            max_ff       <= '0;
            min_ff       <= '1;
         end

         // ram read data comes back in the cycle after the address is issued
         rd_pend_ff <= scan_issue;
         if (scan_issue) begin
            scan_addr_ff <= scan_addr_ff + CNT_W'(1);
         end
         if (rd_pend_ff) begin
            sum_ff <= sum_ff + SUM_W'(ram_rd_data);
            if (ram_rd_data > max_ff) begin
               max_ff <= ram_rd_data;
            end
            if (ram_rd_data < min_ff) begin
               min_ff <= ram_rd_data;
            end
         end

         if (state_ff == ST_MDIV && div_stat.done) begin
            mean_ff <= div_quotient[TEMP_W-1:0];
         end

         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_temperature_ff  <= temp_ff;
         rsp_zone_ff         <= zone_ff;
         rsp_stored_count_ff <= STORED_W'(cnt_ff);
         rsp_window_mean_ff  <= mean_ff;
         rsp_window_max_ff   <= max_ff;
         rsp_window_min_ff   <= min_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_temperature  = rsp_temperature_ff;
   assign rsp_zone         = rsp_zone_ff;
   assign rsp_stored_count = rsp_stored_count_ff;
   assign rsp_window_mean  = rsp_window_mean_ff;
   assign rsp_window_max   = rsp_window_max_ff;
   assign rsp_window_min   = rsp_window_min_ff;

   `WTS_ASSERT_ALWAYS(a_cnt_bound, clock, reset, cnt_ff <= CNT_W'(DEPTH), "fill count above depth")
   `WTS_ASSERT_IMP(a_scan_written, clock, reset, scan_issue, scan_addr_ff < cnt_ff && cnt_ff != '0, "scan past stored readings")
   `WTS_ASSERT_IMP(a_accept_units_idle, clock, reset, req_accept, !mul_stat.busy && !div_stat.busy, "item taken while units busy")

endmodule

// ===== test/testbench.sv =====
module testbench;
   import wts_pkg::*;

   typedef struct packed {
      logic [TEMP_W-1:0]   temperature;
      logic [ZONE_W-1:0]   zone;
      logic [STORED_W-1:0] stored_count;
      logic [TEMP_W-1:0]   window_mean;
      logic [TEMP_W-1:0]   window_max;
      logic [TEMP_W-1:0]   window_min;
   } window_stats_type;

   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 152;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;
   localparam logic [THR_W-1:0] THR_ALL_ONES = '1;
   localparam logic [THR_W-1:0] THR_RANGE_TOP = 14'd15000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [CODE_W-1:0]    req_adc_code = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [TEMP_W-1:0]    rsp_temperature;
   logic [ZONE_W-1:0]    rsp_zone;
   logic [STORED_W-1:0]  rsp_stored_count;
   logic [TEMP_W-1:0]    rsp_window_mean;
   logic [TEMP_W-1:0]    rsp_window_max;
   logic [TEMP_W-1:0]    rsp_window_min;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [THR_W-1:0]     csr_wdata = '0;

   logic [CODE_W-1:0] code_queue [$];
   window_stats_type  expected_stats [$];
   int queued_count   = 0;
   int accepted_count = 0;
   int mismatch_count = 0;
   int send_gap       = 0;
   int stall_left     = 0;
   bit calm           = 1'b0;
   bit lazy_sender    = 1'b0;
   bit slow_receiver  = 1'b0;

   // shadow of the block's thresholds and reading window
   logic [THR_W-1:0]  low_limit  = LOW_THR_RESET;
   logic [THR_W-1:0]  high_limit = HIGH_THR_RESET;
   logic [TEMP_W-1:0] history [DEPTH];
   int next_slot = 0;
   int filled    = 0;

   windowed_temperature_stats u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_adc_code     (req_adc_code),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_temperature  (rsp_temperature),
      .rsp_zone         (rsp_zone),
      .rsp_stored_count (rsp_stored_count),
      .rsp_window_mean  (rsp_window_mean),
      .rsp_window_max   (rsp_window_max),
      .rsp_window_min   (rsp_window_min),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [TEMP_W-1:0] to_hundredths(int unsigned code);
      return TEMP_W'((code * FULL_SCALE) / CODE_MAX);
   endfunction

   // converts, classifies and folds one reading into the shadow window
   function automatic window_stats_type predict_stats(logic [CODE_W-1:0] code);
      window_stats_type s;
      logic [TEMP_W-1:0] reading;
      int unsigned sum;
      logic [TEMP_W-1:0] hi_val;
      logic [TEMP_W-1:0] lo_val;
      reading = to_hundredths(32'(code));
      s.temperature = reading;
      // cold wins when the limits are crossed
      if (reading < TEMP_W'(low_limit))
         s.zone = ZONE_COLD;
      else if (reading >= TEMP_W'(high_limit))
         s.zone = ZONE_CRITICAL;
      else
         s.zone = ZONE_NORMAL;
      history[next_slot] = reading;
      next_slot = (next_slot + 1) % DEPTH;
      if (filled < DEPTH)
         filled++;
      sum = 0;
      hi_val = history[0];
      lo_val = history[0];
      for (int i = 0; i < filled; i++) begin
         sum += 32'(history[i]);
         if (history[i] > hi_val)
            hi_val = history[i];
         if (history[i] < lo_val)
            lo_val = history[i];
      end
      s.stored_count = STORED_W'(filled);
      s.window_mean  = TEMP_W'(sum / filled);
      s.window_max   = hi_val;
      s.window_min   = lo_val;
      return s;
   endfunction

   function automatic bit go_idle(bit reluctant);
      if (calm)
         return 1'b0;
      return reluctant ? ($urandom_range(0, 31) != 0) : ($urandom_range(0, 7) == 0);
   endfunction

   function automatic logic [CODE_W-1:0] near_code(logic [THR_W-1:0] limit);
      int unsigned n;
      n = 32'(limit) * CODE_MAX / FULL_SCALE + $urandom_range(0, 2);
      return CODE_W'((n > CODE_MAX) ? CODE_MAX : n);
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic push_code(logic [CODE_W-1:0] code);
      code_queue.push_back(code);
      queued_count++;
   endtask

   task automatic drain();
      do
         @(negedge clock);
      while (accepted_count != queued_count || expected_stats.size() != 0);
   endtask

   // only called with the block idle
   task automatic write_csr(logic [CSR_IDX_W-1:0] index, logic [THR_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (index == CSR_LOW_THRESHOLD)
         low_limit = data;
      else if (index == CSR_HIGH_THRESHOLD)
         high_limit = data;
   endtask

   // driver: holds an item while stalled, idles in bursts between items
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_stats.push_back(predict_stats(req_adc_code));
            accepted_count++;
            lazy_sender = ($urandom_range(0, 3) == 0);
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (code_queue.size() != 0 && go_idle(lazy_sender)) begin
               send_gap = $urandom_range(0, 5);
               req_valid <= 1'b0;
            end else if (code_queue.size() != 0) begin
               req_valid    <= 1'b1;
               req_adc_code <= code_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each accepted result, stalls in bursts
   always @(posedge clock) begin
      window_stats_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_stats.size() == 0) begin
               $error("result with no item waiting: temperature %0d", rsp_temperature);
               mismatch_count++;
            end else begin
               want = expected_stats.pop_front();
               check_field("temperature", 32'(want.temperature), 32'(rsp_temperature));
               check_field("zone", 32'(want.zone), 32'(rsp_zone));
               check_field("stored_count", 32'(want.stored_count), 32'(rsp_stored_count));
               check_field("window_mean", 32'(want.window_mean), 32'(rsp_window_mean));
               check_field("window_max", 32'(want.window_max), 32'(rsp_window_max));
               check_field("window_min", 32'(want.window_min), 32'(rsp_window_min));
            end
            slow_receiver = ($urandom_range(0, 3) == 0);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (go_idle(slow_receiver)) begin
            stall_left = $urandom_range(0, 5);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int reset_codes [11] = '{0, 1023, 1, 40, 41, 61, 62, 341, 682, 512, 511};
      int split_codes [6]  = '{99, 100, 101, 199, 200, 201};
      int crossed_codes [5] = '{299, 300, 599, 600, 1000};
      logic [THR_W-1:0]  lo;
      logic [THR_W-1:0]  hi;
      logic [CODE_W-1:0] code;
      logic [CODE_W-1:0] prev;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset limits: both sides of 20 and 30 degrees, full scale, alternating bits
      foreach (reset_codes[i])
         push_code(CODE_W'(reset_codes[i]));
      drain();

      // limits landing exactly on converted readings; spare indexes must be ignored
      write_csr(CSR_LOW_THRESHOLD, THR_W'(to_hundredths(100)));
      write_csr(CSR_HIGH_THRESHOLD, THR_W'(to_hundredths(200)));
      write_csr(CSR_SPARE_A, THR_ALL_ONES);
      write_csr(CSR_SPARE_B, '0);
      foreach (split_codes[i])
         push_code(CODE_W'(split_codes[i]));
      drain();

      // crossed limits
      write_csr(CSR_LOW_THRESHOLD, THR_W'(to_hundredths(600)));
      write_csr(CSR_HIGH_THRESHOLD, THR_W'(to_hundredths(300)));
      foreach (crossed_codes[i])
         push_code(CODE_W'(crossed_codes[i]));
      drain();

      prev = '0;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin
               lo = '0;
               hi = '0;
            end
            1: begin
               lo = THR_ALL_ONES;
               hi = THR_ALL_ONES;
            end
            2: begin
               lo = '0;
               hi = THR_ALL_ONES;
            end
            3: begin
               lo = THR_ALL_ONES;
               hi = '0;
            end
            4: begin
               lo = THR_RANGE_TOP;
               hi = THR_RANGE_TOP;
            end
            default: begin
               lo = THR_W'($urandom_range(0, 15000));
               hi = THR_W'($urandom_range(0, 15000));
            end
         endcase
         calm = (p == RANDOM_PHASES - 1) || ($urandom_range(0, 5) == 0);
         write_csr(CSR_HIGH_THRESHOLD, hi);
         write_csr(CSR_LOW_THRESHOLD, lo);
         if ($urandom_range(0, 2) == 0)
            write_csr($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, THR_W'($urandom));
         repeat (PHASE_ITEMS) begin
            case ($urandom_range(0, 9))
               0: code = '0;
               1: code = '1;
               2: code = near_code(lo);
               3: code = near_code(hi);
               // slow drift so extremes age out of the window
               4, 5: code = CODE_W'(32'(prev) + $urandom_range(0, 8) - 4);
               default: code = CODE_W'($urandom_range(0, 1023));
            endcase
            prev = code;
            push_code(code);
         end
         drain();
      end

      repeat (110) @(posedge clock);
      if (mismatch_count == 0 && expected_stats.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
